@@ rtl/matrix_multiply_4x4_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the matrix multiply core
// Shared shorthand for clocked implication checks with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_4X4_CORE_MACROS_SVH
`define MATRIX_MULTIPLY_4X4_CORE_MACROS_SVH

// Same-cycle implication: ante holds -> cons holds in that cycle.
`define MM4_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: ante holds -> cons holds in the next cycle.
`define MM4_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mm4x4_pkg.sv @@
// ----------------------------------------------------------------------------
// mm4x4_pkg
// Beat types and fixed constants shared by the matrix multiply core.
// ----------------------------------------------------------------------------
package mm4x4_pkg;

    localparam int IDX_W     = 2;   // row/column field width on the ports
    localparam int ELEM_W    = 32;  // element field width on the ports
    localparam int FRAC_BITS = 16;  // Q16.16

    typedef struct packed {
        logic                     load_right;
        logic [IDX_W-1:0]         row_index;
        logic [IDX_W-1:0]         col_index;
        logic signed [ELEM_W-1:0] element_value;
        logic                     start_multiply;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [ELEM_W-1:0] product_value;
        logic                     saturated;
        logic                     last_element;
    } t_out_item;

    // Controller -> datapath commands
    typedef struct packed {
        logic wr_en;     // store the input element
        logic rd_en;     // read A and B operands
        logic mul_hi;    // multiplier uses upper half of B
        logic acc_lo;    // accumulate low partial product
        logic acc_first; // first term of an element: load instead of add
        logic acc_hi;    // accumulate shifted high partial product
        logic finish;    // round, saturate and present the element
        logic last;      // element is the final one of the run
    } t_dp_cmd;

endpackage

@@ rtl/mm4x4_ctrl.sv @@
// ----------------------------------------------------------------------------
// mm4x4_ctrl
// Sequencer: walks rows, columns and inner-product terms and drives the
// datapath with one command word per cycle.
// ----------------------------------------------------------------------------
`include "matrix_multiply_4x4_core_macros.svh"

module mm4x4_ctrl #(
    parameter int DIM = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic                    i_start_multiply,
    output logic                    o_busy,
    output mm4x4_pkg::t_dp_cmd      o_cmd,
    output logic [$clog2(DIM)-1:0]  o_rd_row,
    output logic [$clog2(DIM)-1:0]  o_rd_col,
    output logic [$clog2(DIM)-1:0]  o_rd_k,
    output logic [$clog2(DIM)-1:0]  o_res_row,
    output logic [$clog2(DIM)-1:0]  o_res_col
);

    localparam int IW = $clog2(DIM);
    localparam logic [IW-1:0] LAST = IW'(DIM - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_MUL_LO = 6'b000100,
        S_MUL_HI = 6'b001000,
        S_ACC_HI = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_row, n_row;
    logic [IW-1:0]   r_col, n_col;
    logic [IW-1:0]   r_k, n_k;
    mm4x4_pkg::t_dp_cmd cmd;

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_k     = r_k;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                cmd.wr_en = i_start;
                if (i_start && i_start_multiply) begin
                    n_row   = '0;
                    n_col   = '0;
                    n_k     = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_en = 1'b1;
                n_state   = S_MUL_LO;
            end
            S_MUL_LO: begin
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                cmd.mul_hi    = 1'b1;
                cmd.acc_lo    = 1'b1;
                cmd.acc_first = (r_k == '0);
                n_state       = S_ACC_HI;
            end
            S_ACC_HI: begin
                cmd.acc_hi = 1'b1;
                if (r_k != LAST) begin
                    // next term's operands load while the high half is added
                    n_k       = r_k + 1'b1;
                    cmd.rd_en = 1'b1;
                    n_state   = S_MUL_LO;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                cmd.finish = 1'b1;
                cmd.last   = (r_row == LAST) && (r_col == LAST);
                if (cmd.last) begin
                    n_state = S_IDLE;
                end else begin
                    n_k = '0;
                    if (r_col == LAST) begin
                        n_col = '0;
                        n_row = r_row + 1'b1;
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                    cmd.rd_en = 1'b1;
                    n_state   = S_MUL_LO;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_col   <= n_col;
            r_k     <= n_k;
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_cmd     = cmd;
    assign o_rd_row  = n_row;
    assign o_rd_col  = n_col;
    assign o_rd_k    = n_k;
    assign o_res_row = r_row;
    assign o_res_col = r_col;

    `MM4_ASSERT_NOW(a_no_rd_on_wr, i_clk, i_rst_n, cmd.wr_en, !cmd.rd_en, "store write collides with operand read")
    `MM4_ASSERT_NEXT(a_last_to_idle, i_clk, i_rst_n, cmd.finish && cmd.last, r_state == S_IDLE, "run did not end after last element")
    `MM4_ASSERT_NEXT(a_mult_starts, i_clk, i_rst_n, cmd.wr_en && i_start_multiply, r_state == S_READ, "multiply beat did not start a run")

endmodule

@@ rtl/mm4x4_datapath.sv @@
// ----------------------------------------------------------------------------
// mm4x4_datapath
// Operand stores, one shared half-width multiplier, accumulator, and the
// round/saturate stage feeding the result register.
// ----------------------------------------------------------------------------
`include "matrix_multiply_4x4_core_macros.svh"

module mm4x4_datapath #(
    parameter int DIM         = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mm4x4_pkg::t_in_item     i_item,
    input  mm4x4_pkg::t_dp_cmd      i_cmd,
    input  logic [$clog2(DIM)-1:0]  i_rd_row,
    input  logic [$clog2(DIM)-1:0]  i_rd_col,
    input  logic [$clog2(DIM)-1:0]  i_rd_k,
    input  logic [$clog2(DIM)-1:0]  i_res_row,
    input  logic [$clog2(DIM)-1:0]  i_res_col,
    output logic                    o_strobe,
    output mm4x4_pkg::t_out_item    o_result
);

    localparam int VW    = VALUE_WIDTH;
    localparam int CELLS = DIM * DIM;
    localparam int AW    = $clog2(CELLS);
    localparam int H     = VW / 2;           // B split point
    localparam int BOW   = VW - H + 1;       // multiplier B operand width
    localparam int PW    = VW + BOW;         // partial product width
    localparam int ACC_W = 2 * VW + $clog2(DIM) + 1;
    localparam int EW    = mm4x4_pkg::ELEM_W;

    // ---------------- operand stores ----------------
    logic [VW-1:0]    r_left_mem  [CELLS];
    logic [VW-1:0]    r_right_mem [CELLS];
    logic [CELLS-1:0] r_left_vld;
    logic [CELLS-1:0] r_right_vld;

    logic [VW+EW-1:0] in_x;
    logic [VW-1:0]    wr_val;
    logic             wr_ok;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    a_addr;
    logic [AW-1:0]    b_addr;

    // element is zero-extended or truncated to the store width
    assign in_x    = {{VW{1'b0}}, i_item.element_value};
    assign wr_val  = in_x[VW-1:0];
    assign wr_ok   = i_cmd.wr_en && (32'(i_item.row_index) < DIM)
                     && (32'(i_item.col_index) < DIM);
    assign wr_addr = AW'(32'(i_item.row_index) * DIM + 32'(i_item.col_index));
    assign a_addr  = AW'(32'(i_rd_row) * DIM + 32'(i_rd_k));
    assign b_addr  = AW'(32'(i_rd_k) * DIM + 32'(i_rd_col));

    logic signed [VW-1:0] r_rd_a;
    logic [VW-1:0]        r_rd_b;

    always_ff @(posedge i_clk) begin
        if (wr_ok && !i_item.load_right) begin
            r_left_mem[wr_addr] <= wr_val;
        end
        if (wr_ok && i_item.load_right) begin
            r_right_mem[wr_addr] <= wr_val;
        end
        // never-written entries read as zero
        if (i_cmd.rd_en) begin
            r_rd_a <= r_left_vld[a_addr] ? r_left_mem[a_addr] : '0;
            r_rd_b <= r_right_vld[b_addr] ? r_right_mem[b_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_vld  <= '0;
            r_right_vld <= '0;
        end else if (wr_ok) begin
            if (i_item.load_right) begin
                r_right_vld[wr_addr] <= 1'b1;
            end else begin
                r_left_vld[wr_addr] <= 1'b1;
            end
        end
    end

    // ---------------- multiply / accumulate ----------------
    // A x B = A x B_lo + (A x B_hi) << H, one half per cycle
    logic signed [BOW-1:0] b_op;
    logic signed [PW-1:0]  prod_w;
    logic signed [PW-1:0]  r_prod;
    logic signed [ACC_W-1:0] prod_x;
    logic signed [ACC_W-1:0] r_acc;

    assign b_op   = i_cmd.mul_hi ? $signed({r_rd_b[VW-1], r_rd_b[VW-1:H]})
                                 : $signed({{(BOW-H){1'b0}}, r_rd_b[H-1:0]});
    assign prod_w = PW'(r_rd_a) * PW'(b_op);
    assign prod_x = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_prod <= prod_w;
        if (i_cmd.acc_lo) begin
            r_acc <= i_cmd.acc_first ? prod_x : r_acc + prod_x;
        end else if (i_cmd.acc_hi) begin
            r_acc <= r_acc + (prod_x <<< H);
        end
    end

    // ---------------- round toward -inf and saturate ----------------
    logic signed [ACC_W-1:0] sh;
    logic                    pos_sat;
    logic                    neg_sat;
    logic [VW-1:0]           res;
    logic [VW+EW-1:0]        res_x;

    assign sh      = r_acc >>> mm4x4_pkg::FRAC_BITS;
    assign pos_sat = !sh[ACC_W-1] && (|sh[ACC_W-1:VW-1]);
    assign neg_sat = sh[ACC_W-1] && !(&sh[ACC_W-1:VW-1]);

    always_comb begin
        if (pos_sat) begin
            res = {1'b0, {(VW-1){1'b1}}};
        end else if (neg_sat) begin
            res = {1'b1, {(VW-1){1'b0}}};
        end else begin
            res = sh[VW-1:0];
        end
    end

    assign res_x = {{EW{1'b0}}, res};

    mm4x4_pkg::t_out_item r_result;
    logic                 r_strobe;

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_result.out_row       <= mm4x4_pkg::IDX_W'(i_res_row);
            r_result.out_col       <= mm4x4_pkg::IDX_W'(i_res_col);
            r_result.product_value <= $signed(res_x[EW-1:0]);
            r_result.saturated     <= pos_sat || neg_sat;
            r_result.last_element  <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.finish;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `MM4_ASSERT_NEXT(a_strobe_spaced, i_clk, i_rst_n, r_strobe, !r_strobe, "result beats back to back")
    `MM4_ASSERT_NOW(a_last_corner, i_clk, i_rst_n, r_strobe && r_result.last_element, (r_result.out_row == mm4x4_pkg::IDX_W'(DIM - 1)) && (r_result.out_col == mm4x4_pkg::IDX_W'(DIM - 1)), "last flag off the final element")

endmodule

@@ rtl/matrix_multiply_4x4_core.sv @@
// ----------------------------------------------------------------------------
// matrix_multiply_4x4_core
// C = A x B over DIM x DIM signed fixed-point matrices (Q16.16 by default).
// ----------------------------------------------------------------------------
// Usage: while busy is low, each start beat stores one element of A or B,
// one beat per cycle; out-of-range indexes are dropped. A beat with
// start_multiply set stores its element and then runs the product: busy
// rises, and DIM*DIM result beats follow in row-major order, each on
// o_result for a single cycle with o_result_strobe high. Busy drops in the
// cycle the last result is shown. The pace is set by the one shared
// multiplier, which takes each inner-product term in two halves of B, plus
// a finish step per element to round and saturate. Results cannot be
// stalled; capture them on the strobe. Both stores read as zero after reset
// and keep their contents across runs.
// ----------------------------------------------------------------------------
module matrix_multiply_4x4_core #(
    parameter int DIM         = 4,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  mm4x4_pkg::t_in_item   i_item,
    output logic                  busy,
    output logic                  o_result_strobe,
    output mm4x4_pkg::t_out_item  o_result
);

    localparam int IW = $clog2(DIM);

    mm4x4_pkg::t_dp_cmd cmd;
    logic [IW-1:0]      rd_row;
    logic [IW-1:0]      rd_col;
    logic [IW-1:0]      rd_k;
    logic [IW-1:0]      res_row;
    logic [IW-1:0]      res_col;

    mm4x4_ctrl #(
        .DIM (DIM)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_start_multiply (i_item.start_multiply),
        .o_busy           (busy),
        .o_cmd            (cmd),
        .o_rd_row         (rd_row),
        .o_rd_col         (rd_col),
        .o_rd_k           (rd_k),
        .o_res_row        (res_row),
        .o_res_col        (res_col)
    );

    mm4x4_datapath #(
        .DIM         (DIM),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_cmd     (cmd),
        .i_rd_row  (rd_row),
        .i_rd_col  (rd_col),
        .i_rd_k    (rd_k),
        .i_res_row (res_row),
        .i_res_col (res_col),
        .o_strobe  (o_result_strobe),
        .o_result  (o_result)
    );

endmodule
